/* hdl/number_to_english_words_core_defines.svh */
// Assertion macros for the number-to-words block.
// Used by the checker; depends on nothing else.
`ifndef NUMBER_TO_ENGLISH_WORDS_CORE_DEFINES_SVH
`define NUMBER_TO_ENGLISH_WORDS_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define N2W_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define N2W_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also runs through reset.
`define N2W_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/n2w_pkg.sv */
// Shared types and word codes for the number-to-words block.
// No dependencies.
`timescale 1ns / 1ps

package n2w_pkg;

  localparam int BIN_W  = 31;
  localparam int DIGITS = 10;
  localparam int CODE_W = 5;
  localparam int CNT_W  = $clog2(BIN_W);

  // Word codes.
  localparam logic [CODE_W-1:0] W_ZERO      = 5'd0;
  localparam logic [CODE_W-1:0] W_TEEN_BASE = 5'd10;
  localparam logic [CODE_W-1:0] W_TENS_BASE = 5'd18;  // Twenty is tens digit two
  localparam logic [CODE_W-1:0] W_HUNDRED   = 5'd28;
  localparam logic [CODE_W-1:0] W_BILLION   = 5'd31;

  typedef logic [3:0] bcd_digit_t;
  typedef bcd_digit_t [DIGITS-1:0] bcd_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              last;
  } tok_t;

endpackage

/* hdl/n2w_stream_if.sv */
// Handshake channels for the number-to-words block: number in, words out.
// Depends on n2w_pkg.
`timescale 1ns / 1ps

interface n2w_in_if;
  import n2w_pkg::*;
  logic             valid;
  logic             ready;
  logic [BIN_W-1:0] number_value;
  modport source (output valid, output number_value, input ready);
  modport sink (input valid, input number_value, output ready);
endinterface

interface n2w_out_if;
  import n2w_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] word_code;
  logic              last_word;
  modport source (output valid, output word_code, output last_word, input ready);
  modport sink (input valid, input word_code, input last_word, output ready);
endinterface

/* hdl/n2w_bcd.sv */
// Iterative binary to BCD converter, shift-and-add-three, one bit per cycle.
// Depends on n2w_pkg.
`timescale 1ns / 1ps

module n2w_bcd
  import n2w_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [BIN_W-1:0] bin,
  output logic             done,
  output bcd_word_t        digits
);

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(BIN_W - 1);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [BIN_W-1:0]       bin_r;
  bcd_word_t              bcd_r;
  logic [DIGITS*4-1:0]    adj;
  bcd_word_t              bcd_nxt;

  // Add three to every digit of five or more, then shift in the next bit.
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
    bcd_nxt = bcd_word_t'({adj[DIGITS*4-2:0], bin_r[BIN_W-1]});
  end

  // Control: count the shifts and pulse done after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift register for the binary value and the digit register.
  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= bin;
      bcd_r <= '0;
    end else if (busy_r) begin
      bin_r <= {bin_r[BIN_W-2:0], 1'b0};
      bcd_r <= bcd_nxt;
    end
  end

  assign done   = done_r;
  assign digits = bcd_r;

endmodule

/* hdl/n2w_emit.sv */
// Word sequencer: walks the billion, million, thousand and unit groups of
// the decimal digits and emits at most one word item per step. Depends on n2w_pkg.
`timescale 1ns / 1ps

module n2w_emit
  import n2w_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  bcd_word_t digits,
  output logic      done,
  output logic      tok_valid,
  input  logic      tok_ready,
  output tok_t      tok
);

  // Steps within one group, plus the lone Zero word and idle.
  localparam logic [2:0] PH_HD   = 3'd0;  // hundreds digit
  localparam logic [2:0] PH_HW   = 3'd1;  // Hundred
  localparam logic [2:0] PH_TN   = 3'd2;  // unit, teen or tens word
  localparam logic [2:0] PH_UN   = 3'd3;  // unit after a tens word
  localparam logic [2:0] PH_SC   = 3'd4;  // scale word
  localparam logic [2:0] PH_ZERO = 3'd5;
  localparam logic [2:0] PH_IDLE = 3'd6;

  localparam logic [1:0] GRP_UNIT = 2'd3;

  logic [2:0]        phase_r, phase_nxt;
  logic [1:0]        grp_r, grp_nxt;
  logic              out_valid_r;
  tok_t              out_tok_r;
  logic [3:0]        grp_nz;
  bcd_digit_t        h, t, u;
  logic              has_hd, has_tn, has_un, has_sc;
  logic              lower_nz, more, cur_has, cur_last;
  logic [CODE_W-1:0] cur_code, tn_code;
  logic              slot_free, stall, emit, fin;

  // Which groups hold a non-zero value; billion is group 0.
  assign grp_nz[0] = (digits[9] != 4'd0);
  assign grp_nz[1] = |{digits[8], digits[7], digits[6]};
  assign grp_nz[2] = |{digits[5], digits[4], digits[3]};
  assign grp_nz[3] = |{digits[2], digits[1], digits[0]};

  // Digits and later non-zero groups for the current group.
  always_comb begin
    unique case (grp_r)
      2'd0: begin
        h = 4'd0;      t = 4'd0;      u = digits[9];
        lower_nz = |grp_nz[3:1];
      end
      2'd1: begin
        h = digits[8]; t = digits[7]; u = digits[6];
        lower_nz = |grp_nz[3:2];
      end
      2'd2: begin
        h = digits[5]; t = digits[4]; u = digits[3];
        lower_nz = grp_nz[3];
      end
      default: begin
        h = digits[2]; t = digits[1]; u = digits[0];
        lower_nz = 1'b0;
      end
    endcase
  end

  // Which steps of this group give a word.
  assign has_hd = (h != 4'd0);
  assign has_tn = (t != 4'd0) || (u != 4'd0);
  assign has_un = (t >= 4'd2) && (u != 4'd0);
  assign has_sc = (grp_r != GRP_UNIT) && grp_nz[grp_r];

  always_comb begin
    if (t == 4'd0) begin
      tn_code = {1'b0, u};
    end else if (t == 4'd1) begin
      tn_code = W_TEEN_BASE + {1'b0, u};
    end else begin
      tn_code = W_TENS_BASE + {1'b0, t};
    end
  end

  // Word of the current step and whether any word follows it.
  always_comb begin
    cur_has  = 1'b0;
    cur_code = W_ZERO;
    more     = 1'b0;
    unique case (phase_r)
      PH_HD: begin
        cur_has  = has_hd;
        cur_code = {1'b0, h};
        more     = has_hd | has_tn | has_un | has_sc;
      end
      PH_HW: begin
        cur_has  = has_hd;
        cur_code = W_HUNDRED;
        more     = has_tn | has_un | has_sc;
      end
      PH_TN: begin
        cur_has  = has_tn;
        cur_code = tn_code;
        more     = has_un | has_sc;
      end
      PH_UN: begin
        cur_has  = has_un;
        cur_code = {1'b0, u};
        more     = has_sc;
      end
      PH_SC: begin
        cur_has  = has_sc;
        cur_code = W_BILLION - {3'b000, grp_r};
      end
      PH_ZERO: begin
        cur_has  = 1'b1;
        cur_code = W_ZERO;
      end
      default: begin
        cur_has = 1'b0;
      end
    endcase
    cur_last = (phase_r == PH_ZERO) || !(more || lower_nz);
  end

  assign slot_free = !out_valid_r || tok_ready;
  assign stall     = cur_has && !slot_free;
  assign emit      = cur_has && slot_free;

  // Step sequencing; a group that is zero is passed over in one step.
  always_comb begin
    phase_nxt = phase_r;
    grp_nxt   = grp_r;
    fin       = 1'b0;
    if (start) begin
      phase_nxt = (grp_nz == 4'd0) ? PH_ZERO : PH_HD;
      grp_nxt   = 2'd0;
    end else if (phase_r != PH_IDLE && !stall) begin
      if (emit && cur_last) begin
        phase_nxt = PH_IDLE;
        fin       = 1'b1;
      end else begin
        unique case (phase_r)
          PH_HD: begin
            if (grp_nz[grp_r]) begin
              phase_nxt = PH_HW;
            end else if (grp_r == GRP_UNIT) begin
              phase_nxt = PH_IDLE;
              fin       = 1'b1;
            end else begin
              grp_nxt = grp_r + 2'd1;
            end
          end
          PH_HW: phase_nxt = PH_TN;
          PH_TN: phase_nxt = PH_UN;
          PH_UN: phase_nxt = PH_SC;
          PH_SC: begin
            if (grp_r == GRP_UNIT) begin
              phase_nxt = PH_IDLE;
              fin       = 1'b1;
            end else begin
              phase_nxt = PH_HD;
              grp_nxt   = grp_r + 2'd1;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            fin       = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      grp_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      grp_r   <= grp_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (tok_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output register holds a word item until it is taken.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_tok_r <= '{code: cur_code, last: cur_last};
    end
  end

  assign done      = fin;
  assign tok_valid = out_valid_r;
  assign tok       = out_tok_r;

endmodule

/* hdl/number_to_english_words_core.sv */
// Number to English words: one item in, its word items out, last one flagged.
// Binary-to-decimal shifting in the add-three converter comes first, then the word steps,
// and output stalls can hold the word steps. A new number is taken only after the last
// word of the previous one has entered the output register. Synchronous reset clears
// all control.
// Depends on n2w_pkg, n2w_stream_if, n2w_bcd and n2w_emit.
`timescale 1ns / 1ps

module number_to_english_words_core
  import n2w_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  n2w_in_if.sink    in_chan,
  n2w_out_if.source out_chan
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       in_acc;
  logic       bcd_done;
  bcd_word_t  digits;
  logic       emit_done;
  logic       tok_valid;
  tok_t       tok;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  n2w_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .bin    (in_chan.number_value),
    .done   (bcd_done),
    .digits (digits)
  );

  n2w_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (bcd_done),
    .digits    (digits),
    .done      (emit_done),
    .tok_valid (tok_valid),
    .tok_ready (out_chan.ready),
    .tok       (tok)
  );

  // Top sequencer: convert, then emit words, then take the next item.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_CONV;
      ST_CONV: if (bcd_done) state_nxt = ST_EMIT;
      ST_EMIT: if (emit_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_chan.valid     = tok_valid;
  assign out_chan.word_code = tok.code;
  assign out_chan.last_word = tok.last;

endmodule

/* hdl/n2w_checker.sv */
// Port-level checks for the number-to-words block, bound to the top level.
// Depends on n2w_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "number_to_english_words_core_defines.svh"

module n2w_checker
  import n2w_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CODE_W-1:0] word_code,
  input logic              last_word
);

  // A held word item keeps its payload.
  `N2W_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(word_code) && $stable(last_word), "stalled word item changed")
  // After a number is taken, input ready drops so that no other is taken straight away.
  `N2W_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while converting")
  // Zero is only ever the single word of a zero input.
  `N2W_ASSERT_IMPLY(a_zero_is_last, out_valid && word_code == W_ZERO, last_word, "Zero word not last")
  // A valid word item carries no unknown bits.
  `N2W_ASSERT_IMPLY(a_code_known, out_valid, !$isunknown({word_code, last_word}), "word item has unknown bits")
  // Reset leaves no word item pending.
  `N2W_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "word item valid after reset")

endmodule

bind number_to_english_words_core n2w_checker u_n2w_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .word_code (out_chan.word_code),
  .last_word (out_chan.last_word)
);
